[rtl/tree_lca_binary_lifting_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the lowest common ancestor block
// Clocked concurrent assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef TREE_LCA_BINARY_LIFTING_TOP_ASSERT_SVH
`define TREE_LCA_BINARY_LIFTING_TOP_ASSERT_SVH

// Assertion on an explicit clock and active-low reset.
`define TLBL_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define TLBL_ASSERT(label, prop, msg) \
  `TLBL_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

[rtl/tlbl_pkg.sv]
// ----------------------------------------------------------------------------
// tlbl_pkg
// Shared widths and codes of the lowest common ancestor block.
// ----------------------------------------------------------------------------
package tlbl_pkg;

  localparam int unsigned ID_W = 16;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

endpackage

[rtl/tlbl_if.sv]
// ----------------------------------------------------------------------------
// tlbl_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface tlbl_req_if import tlbl_pkg::*;;
  logic            valid;
  logic            ready;
  kind_e           kind;
  logic [ID_W-1:0] node_id;
  logic [ID_W-1:0] partner_id;

  modport source (output valid, output kind, output node_id, output partner_id, input ready);
  modport sink (input valid, input kind, input node_id, input partner_id, output ready);
endinterface

interface tlbl_rsp_if import tlbl_pkg::*;;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] ancestor_id;

  modport source (output valid, output ancestor_id, input ready);
  modport sink (input valid, input ancestor_id, output ready);
endinterface

[rtl/tlbl_slot.sv]
// ----------------------------------------------------------------------------
// tlbl_slot
// Two-stage pipeline that maps a node id to its store slot, the id modulo
// NODE_COUNT, by a reciprocal multiply and a back multiply.
// ----------------------------------------------------------------------------
module tlbl_slot import tlbl_pkg::*; #(
  parameter int unsigned NODE_COUNT = 65536
) (
  input  logic                          clk_i,
  input  logic [ID_W-1:0]               id_i,
  output logic [$clog2(NODE_COUNT)-1:0] slot_o
);

  localparam int unsigned SLOT_W = $clog2(NODE_COUNT);
  localparam int unsigned SHIFT  = ID_W + SLOT_W;
  localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(NODE_COUNT) - 64'd1) / 64'(NODE_COUNT);
  localparam int unsigned MUL_W  = $clog2(RECIP + 64'd1);
  localparam int unsigned PROD_W = ID_W + MUL_W;
  localparam longint unsigned N_CLAMP =
      (64'(NODE_COUNT) > (64'd1 << ID_W)) ? (64'd1 << ID_W) : 64'(NODE_COUNT);

  logic [PROD_W-1:0] prod_d, prod_q;
  logic [ID_W-1:0]   id_q;
  logic [PROD_W-1:0] quot_full;
  logic [ID_W-1:0]   quot;
  logic [2*ID_W:0]   back_full;
  logic [ID_W-1:0]   rem;
  logic [SLOT_W-1:0] slot_d, slot_q;

  assign prod_d    = PROD_W'(id_i) * PROD_W'(RECIP);
  assign quot_full = prod_q >> SHIFT;
  assign quot      = quot_full[ID_W-1:0];
  assign back_full = {(ID_W+1)'(0), quot} * (2*ID_W+1)'(N_CLAMP);
  assign rem       = id_q - back_full[ID_W-1:0];
  assign slot_d    = SLOT_W'(rem);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    id_q   <= id_i;
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

[rtl/tree_lca_binary_lifting_top.sv]
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_top
// Lowest common ancestor by binary lifting over a depth store and an
// ancestor table, both held in synchronous memories.
//
// Channel  Dir  Handshake    Payload
// req_i    in   valid/ready  kind, node_id, partner_id
// rsp_o    out  valid/ready  ancestor_id (one item per query)
//
// An insert makes one table read per level. A query lifts the deeper node
// and then descends both nodes, or skips the descent when lifting alone
// meets the other node; each lift step is a table read followed by a
// dependent depth read, each descent step one dual-port read.
// No clearing pass follows reset: an unwritten sentinel row reads as zero.
// One response item waits in the output register while the next request
// item is taken; a query stalls at its end only if that register is full.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_top import tlbl_pkg::*; #(
  parameter int unsigned NODE_COUNT  = 65536,
  parameter int unsigned LIFT_LEVELS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlbl_req_if.sink   req_i,
  tlbl_rsp_if.source rsp_o
);

  localparam int unsigned SLOT_W   = $clog2(NODE_COUNT);
  localparam int unsigned LVL_W    = $clog2(LIFT_LEVELS);
  localparam int unsigned TAB_AW   = SLOT_W + LVL_W;
  localparam int unsigned TAB_SIZE = 1 << TAB_AW;
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LIFT_LEVELS - 1);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_SLOT_A   = 12'b0000_0000_0010,
    ST_SLOT_B   = 12'b0000_0000_0100,
    ST_SLOT_C   = 12'b0000_0000_1000,
    ST_INS_LVL  = 12'b0000_0001_0000,
    ST_Q_DB     = 12'b0000_0010_0000,
    ST_Q_ORDER  = 12'b0000_0100_0000,
    ST_LIFT_D   = 12'b0000_1000_0000,
    ST_LIFT_CMP = 12'b0001_0000_0000,
    ST_DESC     = 12'b0010_0000_0000,
    ST_FINAL    = 12'b0100_0000_0000,
    ST_RSP      = 12'b1000_0000_0000
  } state_e;

  state_e            state_d, state_q;
  logic [LVL_W-1:0]  k_d, k_q;
  kind_e             kind_d, kind_q;
  logic [ID_W-1:0]   node_d, node_q;
  logic [ID_W-1:0]   part_d, part_q;
  logic [SLOT_W-1:0] sn_d, sn_q;
  entry_t            a_d, a_q, b_d, b_q;
  logic [ID_W-1:0]   da_d, da_q, db_d, db_q;
  logic [ID_W-1:0]   res_d, res_q;
  logic              row0_wr_d, row0_wr_q;
  logic              rsp_valid_d, rsp_valid_q;
  logic [ID_W-1:0]   rsp_id_d, rsp_id_q;

  logic [ID_W-1:0]   slot_in;
  logic [SLOT_W-1:0] slot_w;

  logic [ID_W-1:0]   dep_mem [NODE_COUNT];
  logic              dep_we, dep_re;
  logic [SLOT_W-1:0] dep_waddr, dep_raddr;
  logic [ID_W-1:0]   dep_wdata, dep_raw_q, dep_rd;
  logic              dep_zero_d, dep_zero_q;

  entry_t            tab_mem [TAB_SIZE];
  logic              tab_we, tab_re_a, tab_re_b, fwd_a;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr_a, tab_raddr_b;
  entry_t            tab_wdata, tab_a_raw_q, tab_b_raw_q, tab_a, tab_b;
  logic              tab_a_zero_d, tab_a_zero_q, tab_b_zero_d, tab_b_zero_q;

  entry_t            a_next, b_next;

  tlbl_slot #(
    .NODE_COUNT(NODE_COUNT)
  ) u_slot (
    .clk_i (clk_i),
    .id_i  (slot_in),
    .slot_o(slot_w)
  );

  assign dep_rd = dep_zero_q ? '0 : dep_raw_q;
  assign tab_a  = tab_a_zero_q ? '0 : tab_a_raw_q;
  assign tab_b  = tab_b_zero_q ? '0 : tab_b_raw_q;
  assign fwd_a  = tab_we && tab_re_a && (tab_waddr == tab_raddr_a);

  assign tab_a_zero_d = tab_re_a ? ((tab_raddr_a[TAB_AW-1:LVL_W] == '0) && !row0_wr_q && !fwd_a)
                                 : tab_a_zero_q;
  assign tab_b_zero_d = tab_re_b ? ((tab_raddr_b[TAB_AW-1:LVL_W] == '0) && !row0_wr_q)
                                 : tab_b_zero_q;
  assign dep_zero_d   = dep_re ? ((dep_raddr == '0) && !row0_wr_q) : dep_zero_q;

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.ancestor_id = rsp_id_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    kind_d      = kind_q;
    node_d      = node_q;
    part_d      = part_q;
    sn_d        = sn_q;
    a_d         = a_q;
    b_d         = b_q;
    da_d        = da_q;
    db_d        = db_q;
    res_d       = res_q;
    row0_wr_d   = row0_wr_q;
    rsp_valid_d = rsp_valid_q;
    rsp_id_d    = rsp_id_q;
    slot_in     = part_q;
    dep_we      = 1'b0;
    dep_waddr   = sn_q;
    dep_wdata   = dep_rd + ID_W'(1);
    dep_re      = 1'b0;
    dep_raddr   = '0;
    tab_we      = 1'b0;
    tab_waddr   = '0;
    tab_wdata   = '0;
    tab_re_a    = 1'b0;
    tab_raddr_a = '0;
    tab_re_b    = 1'b0;
    tab_raddr_b = '0;
    a_next      = a_q;
    b_next      = b_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        slot_in = req_i.node_id;
        if (req_i.valid) begin
          kind_d  = req_i.kind;
          node_d  = req_i.node_id;
          part_d  = req_i.partner_id;
          state_d = ST_SLOT_A;
        end
      end
      ST_SLOT_A: begin
        state_d = ST_SLOT_B;
      end
      ST_SLOT_B: begin
        sn_d    = slot_w;
        state_d = ST_SLOT_C;
      end
      ST_SLOT_C: begin
        a_d = '{id: node_q, slot: sn_q};
        b_d = '{id: part_q, slot: slot_w};
        if (kind_q == KIND_INSERT) begin
          if (node_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            tab_we      = 1'b1;
            tab_waddr   = {sn_q, LVL_W'(0)};
            tab_wdata   = '{id: part_q, slot: slot_w};
            tab_re_a    = 1'b1;
            tab_raddr_a = {slot_w, LVL_W'(0)};
            dep_re      = 1'b1;
            dep_raddr   = slot_w;
            if (sn_q == '0) begin
              row0_wr_d = 1'b1;
            end
            k_d     = LVL_W'(1);
            state_d = ST_INS_LVL;
          end
        end else begin
          dep_re    = 1'b1;
          dep_raddr = sn_q;
          state_d   = ST_Q_DB;
        end
      end
      ST_INS_LVL: begin
        tab_we    = 1'b1;
        tab_waddr = {sn_q, k_q};
        tab_wdata = tab_a;
        if (k_q == LVL_W'(1)) begin
          dep_we = 1'b1;
        end
        if (k_q == LAST_LVL) begin
          state_d = ST_IDLE;
        end else begin
          tab_re_a    = 1'b1;
          tab_raddr_a = {tab_a.slot, k_q};
          k_d         = k_q + LVL_W'(1);
        end
      end
      ST_Q_DB: begin
        dep_re    = 1'b1;
        dep_raddr = b_q.slot;
        da_d      = dep_rd;
        state_d   = ST_Q_ORDER;
      end
      ST_Q_ORDER: begin
        if (da_q < dep_rd) begin
          a_next = b_q;
          b_next = a_q;
          db_d   = da_q;
        end else begin
          db_d   = dep_rd;
        end
        a_d         = a_next;
        b_d         = b_next;
        tab_re_a    = 1'b1;
        tab_raddr_a = {a_next.slot, LAST_LVL};
        k_d         = LAST_LVL;
        state_d     = ST_LIFT_D;
      end
      ST_LIFT_D: begin
        dep_re    = 1'b1;
        dep_raddr = tab_a.slot;
        state_d   = ST_LIFT_CMP;
      end
      ST_LIFT_CMP: begin
        if (dep_rd >= db_q) begin
          a_next = tab_a;
        end
        a_d = a_next;
        if (k_q == '0) begin
          if (a_next.id == b_q.id) begin
            res_d   = a_next.id;
            state_d = ST_RSP;
          end else begin
            tab_re_a    = 1'b1;
            tab_raddr_a = {a_next.slot, LAST_LVL};
            tab_re_b    = 1'b1;
            tab_raddr_b = {b_q.slot, LAST_LVL};
            k_d         = LAST_LVL;
            state_d     = ST_DESC;
          end
        end else begin
          tab_re_a    = 1'b1;
          tab_raddr_a = {a_next.slot, k_q - LVL_W'(1)};
          k_d         = k_q - LVL_W'(1);
          state_d     = ST_LIFT_D;
        end
      end
      ST_DESC: begin
        if (tab_a.id != tab_b.id) begin
          a_next = tab_a;
          b_next = tab_b;
        end
        a_d = a_next;
        b_d = b_next;
        if (k_q == '0) begin
          tab_re_a    = 1'b1;
          tab_raddr_a = {a_next.slot, LVL_W'(0)};
          state_d     = ST_FINAL;
        end else begin
          tab_re_a    = 1'b1;
          tab_raddr_a = {a_next.slot, k_q - LVL_W'(1)};
          tab_re_b    = 1'b1;
          tab_raddr_b = {b_next.slot, k_q - LVL_W'(1)};
          k_d         = k_q - LVL_W'(1);
        end
      end
      ST_FINAL: begin
        res_d   = tab_a.id;
        state_d = ST_RSP;
      end
      ST_RSP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_id_d    = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      kind_q       <= KIND_INSERT;
      row0_wr_q    <= 1'b0;
      rsp_valid_q  <= 1'b0;
      dep_zero_q   <= 1'b1;
      tab_a_zero_q <= 1'b1;
      tab_b_zero_q <= 1'b1;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      kind_q       <= kind_d;
      row0_wr_q    <= row0_wr_d;
      rsp_valid_q  <= rsp_valid_d;
      dep_zero_q   <= dep_zero_d;
      tab_a_zero_q <= tab_a_zero_d;
      tab_b_zero_q <= tab_b_zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    part_q   <= part_d;
    sn_q     <= sn_d;
    a_q      <= a_d;
    b_q      <= b_d;
    da_q     <= da_d;
    db_q     <= db_d;
    res_q    <= res_d;
    rsp_id_q <= rsp_id_d;
  end

  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[dep_waddr] <= dep_wdata;
    end
    if (dep_re) begin
      dep_raw_q <= dep_mem[dep_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re_a) begin
      tab_a_raw_q <= fwd_a ? tab_wdata : tab_mem[tab_raddr_a];
    end
    if (tab_re_b) begin
      tab_b_raw_q <= tab_mem[tab_raddr_b];
    end
  end

`include "tree_lca_binary_lifting_top_assert.svh"

  `TLBL_ASSERT(a_slot_range, (state_q == ST_SLOT_B || state_q == ST_SLOT_C) |-> (32'(slot_w) < NODE_COUNT), "Slot unit produced a slot beyond the store.")
  `TLBL_ASSERT(a_tab_write_insert, tab_we |-> (kind_q == KIND_INSERT && (state_q == ST_SLOT_C || state_q == ST_INS_LVL)), "Ancestor table written outside an insert.")
  `TLBL_ASSERT(a_rsp_from_query, $rose(rsp_valid_q) |-> (kind_q == KIND_QUERY), "Response item produced by an insert.")
  `TLBL_ASSERT(a_desc_step, (state_q == ST_DESC && k_q != '0) |=> (state_q == ST_DESC && k_q == $past(k_q) - LVL_W'(1)), "Descent did not step down one level.")

endmodule
